### hdl/tsgd_pkg.sv
// ----------------------------------------------------------------------------
// tsgd_pkg
// Shared types, widths, register codes and direction helpers for the touch
// swipe and drag direction detector.
// ----------------------------------------------------------------------------
package tsgd_pkg;

  localparam int COORD_BITS = 12;
  localparam int SUM_BITS   = COORD_BITS + 1;
  localparam int REG_BITS   = 12;
  localparam int CMP_BITS   = (SUM_BITS > REG_BITS) ? SUM_BITS : REG_BITS;
  localparam int IDX_BITS   = 2;

  localparam logic [REG_BITS-1:0] SCROLL_THR_RST  = REG_BITS'(30);
  localparam logic [REG_BITS-1:0] GESTURE_THR_RST = REG_BITS'(50);
  localparam logic [REG_BITS-1:0] MIN_VEL_RST     = REG_BITS'(3);

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [SUM_BITS-1:0] sum_t;
  typedef logic [REG_BITS-1:0]        reg_val_t;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_UP    = 3'd4
  } dir_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_SCROLL_THR  = 2'd0,
    REG_GESTURE_THR = 2'd1,
    REG_MIN_VEL     = 2'd2
  } reg_idx_t;

  // Magnitude of a sum or a step, widened to the common compare width.
  function automatic logic [CMP_BITS-1:0] mag(input sum_t v);
    logic [SUM_BITS-1:0] a;
    a = v[SUM_BITS-1] ? SUM_BITS'(-v) : SUM_BITS'(v);
    return CMP_BITS'(a);
  endfunction

  // Direction along the dominant axis; the x axis wins a tie.
  function automatic dir_t pick_dir(input sum_t sx, input sum_t sy, input reg_val_t limit);
    logic [CMP_BITS-1:0] ax;
    logic [CMP_BITS-1:0] ay;
    logic [CMP_BITS-1:0] lim;
    dir_t                d;
    ax  = mag(sx);
    ay  = mag(sy);
    lim = CMP_BITS'(limit);
    if (ax <= lim && ay <= lim) begin
      d = DIR_NONE;
    end else if (ax >= ay) begin
      d = sx[SUM_BITS-1] ? DIR_LEFT : DIR_RIGHT;
    end else begin
      d = sy[SUM_BITS-1] ? DIR_UP : DIR_DOWN;
    end
    return d;
  endfunction

endpackage

### hdl/touch_swipe_gesture_detect.sv
// ----------------------------------------------------------------------------
// touch_swipe_gesture_detect
// A sample beat passes through the input register and then the result register;
// a stalled output side holds both stages. One sample is taken per cycle while
// the output side is not stalled; the displacement sums update together with
// the result register.
// Reset (rst_n low, synchronous): both stages empty, sums and the previous
// sample cleared, thresholds back to 30, 50 and 3.
// ----------------------------------------------------------------------------
module touch_swipe_gesture_detect (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tsgd_pkg::COORD_BITS-1:0]    in_pos_x,
  input  logic [tsgd_pkg::COORD_BITS-1:0]    in_pos_y,
  input  logic                               in_pressed,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_swipe_dir,
  output logic [2:0]                         out_drag_dir,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tsgd_pkg::IDX_BITS-1:0]      cfg_index,
  input  logic [tsgd_pkg::REG_BITS-1:0]      cfg_data
);

  // Configuration registers.
  tsgd_pkg::reg_val_t scroll_thr_r, gesture_thr_r, min_vel_r;

  // Input stage.
  logic             s1_valid_r;
  tsgd_pkg::coord_t s1_x_r, s1_y_r;
  logic             s1_pr_r;

  // Tracking state.
  tsgd_pkg::coord_t last_x_r, last_y_r;
  logic             last_pr_r;
  tsgd_pkg::sum_t   drag_x_r, drag_y_r, swipe_x_r, swipe_y_r;
  tsgd_pkg::sum_t   drag_x_nxt, drag_y_nxt, swipe_x_nxt, swipe_y_nxt;

  // Result stage.
  logic             out_valid_r;
  tsgd_pkg::dir_t   swipe_r, drag_r, swipe_nxt, drag_nxt;

  logic             advance;
  tsgd_pkg::sum_t   dx, dy, drag_x_add, drag_y_add, swipe_x_add, swipe_y_add;
  logic             slow;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_swipe_dir = swipe_r;
  assign out_drag_dir  = drag_r;

  always_comb begin
    dx = tsgd_pkg::sum_t'({1'b0, s1_x_r}) - tsgd_pkg::sum_t'({1'b0, last_x_r});
    dy = tsgd_pkg::sum_t'({1'b0, s1_y_r}) - tsgd_pkg::sum_t'({1'b0, last_y_r});
    drag_x_add = drag_x_r + dx;
    drag_y_add = drag_y_r + dy;
    slow = (tsgd_pkg::mag(dx) < tsgd_pkg::CMP_BITS'(min_vel_r)) &&
           (tsgd_pkg::mag(dy) < tsgd_pkg::CMP_BITS'(min_vel_r));
    // A slow step restarts the swipe sum before the step is added.
    swipe_x_add = slow ? dx : swipe_x_r + dx;
    swipe_y_add = slow ? dy : swipe_y_r + dy;

    drag_x_nxt  = drag_x_r;
    drag_y_nxt  = drag_y_r;
    swipe_x_nxt = swipe_x_r;
    swipe_y_nxt = swipe_y_r;
    swipe_nxt   = tsgd_pkg::DIR_NONE;
    drag_nxt    = tsgd_pkg::DIR_NONE;
    if (last_pr_r && s1_pr_r) begin
      drag_x_nxt  = drag_x_add;
      drag_y_nxt  = drag_y_add;
      swipe_x_nxt = swipe_x_add;
      swipe_y_nxt = swipe_y_add;
      drag_nxt    = tsgd_pkg::pick_dir(drag_x_add, drag_y_add, scroll_thr_r);
      swipe_nxt   = tsgd_pkg::pick_dir(swipe_x_add, swipe_y_add, gesture_thr_r);
    end else if (last_pr_r) begin
      drag_x_nxt  = '0;
      drag_y_nxt  = '0;
      swipe_x_nxt = '0;
      swipe_y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_thr_r  <= tsgd_pkg::SCROLL_THR_RST;
      gesture_thr_r <= tsgd_pkg::GESTURE_THR_RST;
      min_vel_r     <= tsgd_pkg::MIN_VEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tsgd_pkg::reg_idx_t'(cfg_index))
        tsgd_pkg::REG_SCROLL_THR:  scroll_thr_r  <= cfg_data;
        tsgd_pkg::REG_GESTURE_THR: gesture_thr_r <= cfg_data;
        tsgd_pkg::REG_MIN_VEL:     min_vel_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_pr_r   <= 1'b0;
      drag_x_r    <= '0;
      drag_y_r    <= '0;
      swipe_x_r   <= '0;
      swipe_y_r   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance && s1_valid_r) begin
        last_x_r  <= s1_x_r;
        last_y_r  <= s1_y_r;
        last_pr_r <= s1_pr_r;
        drag_x_r  <= drag_x_nxt;
        drag_y_r  <= drag_y_nxt;
        swipe_x_r <= swipe_x_nxt;
        swipe_y_r <= swipe_y_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x_r  <= in_pos_x;
      s1_y_r  <= in_pos_y;
      s1_pr_r <= in_pressed;
    end
    if (advance && s1_valid_r) begin
      swipe_r <= swipe_nxt;
      drag_r  <= drag_nxt;
    end
  end

endmodule

### hdl/tsgd_checker.sv
// ----------------------------------------------------------------------------
// tsgd_checker
// Port-level checks for the touch swipe and drag direction detector.
// ----------------------------------------------------------------------------
module tsgd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2:0]                      out_swipe_dir,
  input logic [2:0]                      out_drag_dir
);

  // A stalled result beat holds its directions.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_swipe_dir) && $stable(out_drag_dir))
    else $error("result beat changed while stalled");

  // Only the five direction codes ever leave the block.
  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_swipe_dir <= 3'd4) && (out_drag_dir <= 3'd4))
    else $error("direction code out of range");

  // With the result register empty the input side can always take a beat.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind touch_swipe_gesture_detect tsgd_checker u_tsgd_checker (.*);

### tb/touch_swipe_gesture_detect_tb.sv
// ----------------------------------------------------------------------------
// touch_swipe_gesture_detect_tb
// Self-checking bench for the swipe and drag direction detector. Touch strokes
// and noise samples go through a valid/ready driver. Every accepted sample runs
// through a predictor of the previous sample and the displacement sums, and
// each result beat is checked against the oldest predicted direction pair.
// Threshold registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module touch_swipe_gesture_detect_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_MAX = (1 << tsgd_pkg::COORD_BITS) - 1;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_SAMPLES = 215;
  localparam logic [tsgd_pkg::IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    tsgd_pkg::coord_t x;
    tsgd_pkg::coord_t y;
    logic             pressed;
  } touch_sample_t;

  typedef struct {
    tsgd_pkg::dir_t swipe;
    tsgd_pkg::dir_t drag;
  } dir_pair_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  tsgd_pkg::coord_t              in_pos_x = '0;
  tsgd_pkg::coord_t              in_pos_y = '0;
  logic                          in_pressed = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [2:0]                    out_swipe_dir;
  logic [2:0]                    out_drag_dir;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [tsgd_pkg::IDX_BITS-1:0] cfg_index = '0;
  tsgd_pkg::reg_val_t            cfg_data = '0;

  touch_sample_t samples_to_send[$];
  dir_pair_t     dir_expected[$];

  // Predictor state and its copy of the threshold registers.
  tsgd_pkg::reg_val_t drag_limit;
  tsgd_pkg::reg_val_t swipe_limit;
  tsgd_pkg::reg_val_t slow_step;
  tsgd_pkg::coord_t   prev_x;
  tsgd_pkg::coord_t   prev_y;
  logic               prev_pressed;
  tsgd_pkg::sum_t     drag_x;
  tsgd_pkg::sum_t     drag_y;
  tsgd_pkg::sum_t     swipe_x;
  tsgd_pkg::sum_t     swipe_y;

  int  send_idle_pct = 31;
  int  recv_idle_pct = 73;
  bit  in_beat = 1'b0;
  int  out_beats = 0;
  int  mismatches = 0;
  int  stall_cycles = 0;
  int  hold_left = 0;
  int  next_hold_at = 250;
  int  queued = 0;

  touch_swipe_gesture_detect u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pressed   (in_pressed),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_swipe_dir(out_swipe_dir),
    .out_drag_dir (out_drag_dir),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int abs_of(input tsgd_pkg::sum_t v);
    int s;
    s = int'(v);
    return (s < 0) ? -s : s;
  endfunction

  // Direction of the axis with the larger magnitude; x wins a tie.
  function automatic tsgd_pkg::dir_t dominant_dir(input tsgd_pkg::sum_t sx,
                                                  input tsgd_pkg::sum_t sy,
                                                  input tsgd_pkg::reg_val_t lim);
    int ax;
    int ay;
    ax = abs_of(sx);
    ay = abs_of(sy);
    if (ax <= int'(lim) && ay <= int'(lim)) return tsgd_pkg::DIR_NONE;
    if (ax >= ay) return (int'(sx) > 0) ? tsgd_pkg::DIR_RIGHT : tsgd_pkg::DIR_LEFT;
    return (int'(sy) > 0) ? tsgd_pkg::DIR_DOWN : tsgd_pkg::DIR_UP;
  endfunction

  function automatic void reset_tracker();
    drag_limit = tsgd_pkg::SCROLL_THR_RST;
    swipe_limit = tsgd_pkg::GESTURE_THR_RST;
    slow_step = tsgd_pkg::MIN_VEL_RST;
    prev_x = '0;
    prev_y = '0;
    prev_pressed = 1'b0;
    drag_x = '0;
    drag_y = '0;
    swipe_x = '0;
    swipe_y = '0;
  endfunction

  function automatic dir_pair_t track_touch(input touch_sample_t s);
    dir_pair_t      r;
    tsgd_pkg::sum_t dx;
    tsgd_pkg::sum_t dy;
    r.swipe = tsgd_pkg::DIR_NONE;
    r.drag = tsgd_pkg::DIR_NONE;
    dx = tsgd_pkg::sum_t'(int'(s.x) - int'(prev_x));
    dy = tsgd_pkg::sum_t'(int'(s.y) - int'(prev_y));
    if (prev_pressed) begin
      if (s.pressed) begin
        drag_x = drag_x + dx;
        drag_y = drag_y + dy;
        r.drag = dominant_dir(drag_x, drag_y, drag_limit);
        // A slow step on both axes starts a new swipe from here.
        if (abs_of(dx) < int'(slow_step) && abs_of(dy) < int'(slow_step)) begin
          swipe_x = '0;
          swipe_y = '0;
        end
        swipe_x = swipe_x + dx;
        swipe_y = swipe_y + dy;
        r.swipe = dominant_dir(swipe_x, swipe_y, swipe_limit);
      end else begin
        drag_x = '0;
        drag_y = '0;
        swipe_x = '0;
        swipe_y = '0;
      end
    end
    prev_x = s.x;
    prev_y = s.y;
    prev_pressed = s.pressed;
    return r;
  endfunction

  // Monitor, predictor and watchdog, all on the rising edge.
  always @(posedge clk) begin
    touch_sample_t s;
    dir_pair_t     e;
    bit            any_beat;
    in_beat = 1'b0;
    any_beat = 1'b0;
    if (!rst_n) begin
      reset_tracker();
    end else begin
      if (cfg_valid && cfg_ready) begin
        any_beat = 1'b1;
        case (cfg_index)
          tsgd_pkg::REG_SCROLL_THR:  drag_limit = cfg_data;
          tsgd_pkg::REG_GESTURE_THR: swipe_limit = cfg_data;
          tsgd_pkg::REG_MIN_VEL:     slow_step = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        in_beat = 1'b1;
        any_beat = 1'b1;
        s.x = in_pos_x;
        s.y = in_pos_y;
        s.pressed = in_pressed;
        dir_expected.push_back(track_touch(s));
      end
      if (out_valid && out_ready) begin
        any_beat = 1'b1;
        out_beats++;
        if (dir_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result beat with no expected result: swipe %0d drag %0d",
                     $realtime, out_swipe_dir, out_drag_dir);
          end
        end else begin
          e = dir_expected.pop_front();
          if (out_swipe_dir !== e.swipe || out_drag_dir !== e.drag) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] beat %0d: swipe exp %0d got %0d, drag exp %0d got %0d",
                       $realtime, out_beats, e.swipe, out_swipe_dir, e.drag, out_drag_dir);
            end
          end
        end
      end
      stall_cycles = any_beat ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Sample driver: holds a beat until it is taken, idles at random between beats.
  always @(negedge clk) begin
    touch_sample_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_beat) begin
      in_valid <= 1'b1;
    end else if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      s = samples_to_send.pop_front();
      in_valid <= 1'b1;
      in_pos_x <= s.x;
      in_pos_y <= s.y;
      in_pressed <= s.pressed;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver, with an occasional long hold-off so the input backs up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (rst_n && samples_to_send.size() > 20 && out_beats >= next_hold_at) begin
      out_ready <= 1'b0;
      hold_left = HOLD_CYCLES;
      next_hold_at = next_hold_at + 700;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic push_sample(input int x, input int y, input bit p);
    touch_sample_t s;
    s.x = tsgd_pkg::coord_t'(x);
    s.y = tsgd_pkg::coord_t'(y);
    s.pressed = p;
    samples_to_send.push_back(s);
    queued++;
  endtask

  // One finger stroke: pressed samples with random steps, then usually a release.
  task automatic queue_stroke();
    int x;
    int y;
    int moves;
    int step_max;
    int m;
    moves = $urandom_range(2, 20);
    case ($urandom_range(0, 9))
      0, 1:    step_max = 2;
      2, 3, 4: step_max = 8;
      5, 6:    step_max = 40;
      7, 8:    step_max = 150;
      default: step_max = COORD_MAX;
    endcase
    x = $urandom_range(0, COORD_MAX);
    y = $urandom_range(0, COORD_MAX);
    for (int i = 0; i < moves; i++) begin
      m = ($urandom_range(0, 5) == 0) ? 2 : step_max;
      x = x + int'($urandom_range(0, 2 * m)) - m;
      y = y + int'($urandom_range(0, 2 * m)) - m;
      x = (x < 0) ? 0 : (x > COORD_MAX) ? COORD_MAX : x;
      y = (y < 0) ? 0 : (y > COORD_MAX) ? COORD_MAX : y;
      push_sample(x, y, 1'b1);
    end
    // Some strokes just stop without a release.
    if ($urandom_range(0, 9) != 0) begin
      push_sample($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 1'b0);
    end
  endtask

  task automatic write_reg(input logic [tsgd_pkg::IDX_BITS-1:0] idx,
                           input tsgd_pkg::reg_val_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic wait_drained();
    while (samples_to_send.size() != 0 || in_valid || dir_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  initial begin
    tsgd_pkg::reg_val_t scroll_v;
    tsgd_pkg::reg_val_t gesture_v;
    tsgd_pkg::reg_val_t slow_v;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed strokes at the reset thresholds (drag 30, swipe 50, slow 3).
    push_sample(100, 100, 1'b0);
    push_sample(100, 100, 1'b1);
    push_sample(130, 100, 1'b1);
    push_sample(131, 100, 1'b1);
    push_sample(151, 100, 1'b1);
    push_sample(152, 100, 1'b1);
    push_sample(152, 100, 1'b0);
    push_sample(0, 0, 1'b1);
    push_sample(COORD_MAX, COORD_MAX, 1'b1);
    push_sample(0, 0, 1'b1);
    push_sample(0, COORD_MAX, 1'b1);
    push_sample(0, COORD_MAX, 1'b0);
    push_sample(COORD_MAX, COORD_MAX, 1'b1);
    push_sample(0, 0, 1'b1);
    push_sample(0, 0, 1'b0);
    push_sample(2000, 2000, 1'b1);
    push_sample(2000, 1900, 1'b1);
    push_sample(1998, 1898, 1'b1);
    push_sample(1900, 1898, 1'b1);
    push_sample(1700, 1600, 1'b1);
    push_sample(1700, 1600, 1'b0);
    push_sample(COORD_MAX, 0, 1'b0);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin scroll_v = '0; gesture_v = '0; slow_v = '0; end
        1: begin scroll_v = '1; gesture_v = '1; slow_v = '1; end
        2: begin scroll_v = 12'd30; gesture_v = 12'd50; slow_v = 12'd3; end
        3: begin
          scroll_v = tsgd_pkg::reg_val_t'($urandom_range(0, 200));
          gesture_v = tsgd_pkg::reg_val_t'($urandom_range(0, 300));
          slow_v = tsgd_pkg::reg_val_t'($urandom_range(0, 20));
        end
        4: begin scroll_v = 12'd12; gesture_v = 12'd80; slow_v = 12'd1; end
        default: begin
          scroll_v = tsgd_pkg::reg_val_t'($urandom_range(0, 4095));
          gesture_v = tsgd_pkg::reg_val_t'($urandom_range(0, 400));
          slow_v = tsgd_pkg::reg_val_t'($urandom_range(0, 4095));
        end
      endcase
      write_reg(tsgd_pkg::REG_SCROLL_THR, scroll_v);
      write_reg(tsgd_pkg::REG_GESTURE_THR, gesture_v);
      write_reg(tsgd_pkg::REG_MIN_VEL, slow_v);
      if (phase == 1) begin
        write_reg(REG_UNMAPPED, tsgd_pkg::reg_val_t'($urandom_range(0, 4095)));
      end
      @(negedge clk);
      cfg_valid <= 1'b0;

      send_idle_pct = (phase < 2) ? 31 : (phase < 4) ? 73 : 0;
      recv_idle_pct = (phase < 2) ? 73 : (phase < 4) ? 31 : 0;

      queued = 0;
      while (queued < PHASE_SAMPLES) begin
        if ($urandom_range(0, 6) == 0) begin
          push_sample($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      1'($urandom_range(0, 1)));
        end else begin
          queue_stroke();
        end
      end
      wait_drained();
    end

    if (mismatches == 0 && dir_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
